@@ hdl/icack_pkg.sv @@
package icack_pkg;

	localparam int NUM_SOURCES = 128;
	localparam int WORD_W      = 32;
	localparam int BIT_W       = 5;
	localparam int NUM_WORDS   = NUM_SOURCES / WORD_W;
	localparam int WIDX_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int VEC_W       = 8;

	// Stream widths: input tdata carries word_index and write_data, input tuser
	// carries action and reg_kind, output tdata carries the whole result.
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		ACT_RAISE = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_ACK   = 2'd3
	} action_t;

	localparam logic [1:0] KIND_PEND   = 2'd0;
	localparam logic [1:0] KIND_FAST   = 2'd1;
	localparam logic [1:0] KIND_ENABLE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_EXEC   = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_ack;
		logic hit;
		logic last_word;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/icack_ctrl.sv @@
module icack_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  icack_pkg::sts_t sts,
	output icack_pkg::cmd_t cmd
);
	import icack_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				// An acknowledge stays here one word per cycle until a hit or the last word.
				if (!sts.is_ack || sts.hit || sts.last_word) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_EXEC) && !s_tready)
		else $error("accepted transfer did not start execution");

	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && sts.is_ack && !sts.hit && !sts.last_word
		|=> state_q == ST_EXEC)
		else $error("acknowledge scan stopped early");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && !sts.is_ack |=> state_q == ST_FINISH)
		else $error("register access took more than one execute cycle");

endmodule

@@ hdl/icack_dp.sv @@
module icack_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [icack_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [icack_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [icack_pkg::OUT_DATA_W-1:0] m_tdata,
	input  icack_pkg::cmd_t                  cmd,
	output icack_pkg::sts_t                  sts
);
	import icack_pkg::*;

	logic [WORD_W-1:0] pend_q [NUM_WORDS];
	logic [WORD_W-1:0] fast_q [NUM_WORDS];
	logic [WORD_W-1:0] en_q   [NUM_WORDS];

	action_t           act_q;
	logic [1:0]        kind_q;
	logic [1:0]        wi_q;
	logic [WORD_W-1:0] data_q;
	logic [WIDX_W-1:0] ptr_q;

	logic [WORD_W-1:0] res_rd_q;
	logic [VEC_W-1:0]  res_vec_q;
	logic              res_fast_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              is_ack;
	logic              ok;
	logic [WIDX_W-1:0] addr;
	logic [WORD_W-1:0] p_word;
	logic [WORD_W-1:0] f_word;
	logic [WORD_W-1:0] pick;
	logic [WORD_W-1:0] low_onehot;
	logic [BIT_W-1:0]  bit_idx;
	logic              hit;
	logic              last_word;
	logic              irq;
	logic              fiq;

	assign is_ack    = (act_q == ACT_ACK);
	assign ok        = (32'(wi_q) < 32'(NUM_WORDS));
	// One read port: the scan pointer during an acknowledge, the addressed word otherwise.
	assign addr      = is_ack ? ptr_q : WIDX_W'(wi_q);
	assign p_word    = pend_q[addr];
	assign f_word    = p_word & fast_q[addr];
	assign pick      = (f_word != '0) ? f_word : p_word;
	assign low_onehot = pick & (~pick + 1'b1);
	assign hit       = (p_word != '0);
	assign last_word = (ptr_q == WIDX_W'(NUM_WORDS - 1));

	always_comb begin
		bit_idx = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (low_onehot[b]) begin
				bit_idx = bit_idx | BIT_W'(b);
			end
		end
	end

	always_comb begin
		irq = 1'b0;
		fiq = 1'b0;
		for (int w = 0; w < NUM_WORDS; w++) begin
			irq = irq | (|(pend_q[w] & ~fast_q[w]));
			fiq = fiq | (|(pend_q[w] & fast_q[w]));
		end
	end

	assign sts.is_ack    = is_ack;
	assign sts.hit       = hit;
	assign sts.last_word = last_word;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q  <= action_t'(s_tuser[1:0]);
			kind_q <= s_tuser[3:2];
			wi_q   <= s_tdata[1:0];
			data_q <= s_tdata[33:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.accept) begin
			ptr_q <= '0;
		end else if (cmd.exec && is_ack && !hit && !last_word) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				pend_q[w] <= '0;
				fast_q[w] <= '0;
				en_q[w]   <= '0;
			end
		end else if (cmd.exec) begin
			unique case (act_q)
				ACT_RAISE: begin
					if (ok) begin
						pend_q[addr] <= p_word | (data_q & en_q[addr]);
					end
				end
				ACT_WRITE: begin
					if (ok) begin
						unique case (kind_q)
							KIND_PEND:   pend_q[addr] <= p_word & ~data_q;
							KIND_FAST:   fast_q[addr] <= data_q;
							KIND_ENABLE: en_q[addr]   <= data_q;
							default: begin
							end
						endcase
					end
				end
				ACT_READ: begin
				end
				ACT_ACK: begin
					if (hit) begin
						pend_q[addr] <= p_word & ~low_onehot;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_rd_q   <= '0;
			res_vec_q  <= VEC_W'(NUM_SOURCES);
			res_fast_q <= 1'b0;
		end else if (cmd.exec) begin
			if ((act_q == ACT_READ) && ok) begin
				unique case (kind_q)
					KIND_PEND:   res_rd_q <= p_word;
					KIND_FAST:   res_rd_q <= fast_q[addr];
					KIND_ENABLE: res_rd_q <= en_q[addr];
					default:     res_rd_q <= '0;
				endcase
			end
			if (is_ack && hit) begin
				res_vec_q  <= VEC_W'({ptr_q, bit_idx});
				// The lowest fast bit wins whenever the word has one.
				res_fast_q <= (f_word != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Flags are sampled here, after the step has updated the pending words.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= OUT_DATA_W'({fiq, irq, res_fast_q, res_vec_q, res_rd_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid_q)
		else $error("loaded result not presented");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_ack && hit |=> res_vec_q != VEC_W'(NUM_SOURCES))
		else $error("acknowledge hit reported the empty vector");

endmodule

@@ hdl/interrupt_controller_ack.sv @@
// Interrupt controller for 128 sources kept as four 32-bit words of pending,
// fast-select and enable bits. Each input transfer carries one action (raise,
// register write, register read or acknowledge) and yields exactly one result
// transfer. A raise, write or read passes through the execute and finish states,
// so its result reaches the output register before a new item can be taken. An
// acknowledge scans one status word per cycle from word 0, stopping at the first
// word holding a pending source or at the last word. One item is in the execute
// unit at a time. The next is accepted as soon as the result is in the output
// register, even while that result still waits, but that item then stalls in
// its finish state until m_tready frees it.
module interrupt_controller_ack (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [1:0] word_index, [33:2] write_data, [39:34] zero
	input  logic [icack_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] action, [3:2] reg_kind
	input  logic [icack_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] read_data, [39:32] ack_vector, [40] ack_is_fast, [41] irq_out,
	// [42] fiq_out, [47:43] zero
	output logic [icack_pkg::OUT_DATA_W-1:0] m_tdata
);
	import icack_pkg::*;

	cmd_t cmd;
	sts_t sts;

	icack_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icack_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
